[rtl/dfb_pkg.sv]
// Shared types and constants for the dominance frontier builder.
package dfb_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned AddrW     = $clog2(MaxBlocks);
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned RowW      = 64;
  localparam int unsigned NodeW     = IdxW + 2;

  localparam logic [CountW-1:0] CountMax   = CountW'(MaxBlocks);
  localparam logic [CountW-1:0] CountReset = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EDGE  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JOIN,
    ST_STEP,
    ST_RDATA,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic            reach;
    logic            has_dom;
    logic [IdxW-1:0] dom;
  } node_t;

endpackage

[rtl/dfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dominance_frontier_builder_unit.sv]
// Dominance frontier builder: node table and frontier matrix in RAM, climb sequencer.
// Path to the output register: clear, load and rejected items pass ST_FIN; a read
// passes ST_RDATA, ST_FIN; add_edge ST_JOIN, an ST_STEP per chain row, then ST_FIN.
// One item at a time: the next item is taken once the previous result has moved
// into the output register; the climb rate is one RAM read-modify-write per cycle.
// Reset (async, active low) sets block_count to 64 and clears all row and node valid
// flags at once, so no clearing pass is needed; node RAM contents stay undefined.
module dominance_frontier_builder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dfb_pkg::CountW-1:0]  cfg_wdata_i,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [dfb_pkg::IdxW-1:0]    block_i,
  input  logic [dfb_pkg::IdxW-1:0]    dominator_i,
  input  logic                        has_dominator_i,
  input  logic                        reachable_i,
  input  logic [dfb_pkg::IdxW-1:0]    predecessor_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dfb_pkg::RowW-1:0]    frontier_row_o,
  output logic                        status_o
);

  import dfb_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q;
  logic [MaxBlocks-1:0] written_q, written_d;   // node entry has been loaded
  logic [MaxBlocks-1:0] rowv_q, rowv_d;         // frontier row holds data (else zero)
  logic [IdxW-1:0]     join_q, join_d;          // join node, or row for a read
  logic [IdxW-1:0]     runner_q, runner_d;
  logic                jhas_q, jhas_d;          // join has an idom
  logic [IdxW-1:0]     jidom_q, jidom_d;
  logic                first_q, first_d;        // first step: check reachability
  logic [RowW-1:0]     res_row_q, res_row_d;
  logic                res_stat_q, res_stat_d;
  logic                out_valid_q, out_valid_d;
  logic [RowW-1:0]     out_row_q, out_row_d;
  logic                out_stat_q, out_stat_d;

  // RAM ports
  logic                node_we;
  logic [AddrW-1:0]    node_waddr, node_raddr;
  node_t               node_wdata, node_rdata;
  logic                fr_we;
  logic [AddrW-1:0]    fr_waddr, fr_raddr;
  logic [RowW-1:0]     fr_wdata, fr_rdata;

  logic [CountW-1:0]   eff_count;
  logic                in_acc;
  logic                out_free;
  logic                item_err;
  op_e                 op;

  // climb step evaluation
  logic                step_stop;
  logic                nd_valid;
  logic [RowW-1:0]     cur_row;
  logic [RowW-1:0]     join_bit;

  function automatic logic in_range(input logic [IdxW-1:0] idx,
                                    input logic [CountW-1:0] cnt);
    return {{(CountW-IdxW){1'b0}}, idx} < cnt;
  endfunction

  assign eff_count = (count_q > CountMax) ? CountMax : count_q;
  assign op        = op_e'(op_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Index check per op; clear checks nothing.
  always_comb begin
    unique case (op)
      OP_CLEAR: item_err = 1'b0;
      OP_LOAD:  item_err = !in_range(block_i, eff_count) ||
                           (has_dominator_i && !in_range(dominator_i, eff_count));
      OP_EDGE:  item_err = !in_range(block_i, eff_count) ||
                           !in_range(predecessor_i, eff_count);
      OP_READ:  item_err = !in_range(block_i, eff_count);
      default:  item_err = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Climb step: node and frontier data for runner_q arrive this cycle.
  // ---------------------------------------------------------------------------
  assign nd_valid = written_q[runner_q[AddrW-1:0]];
  assign cur_row  = rowv_q[runner_q[AddrW-1:0]] ? fr_rdata : '0;
  assign join_bit = RowW'(1) << join_q;

  always_comb begin
    priority if (first_q && !(nd_valid && node_rdata.reach)) begin
      step_stop = 1'b1;                         // unreachable predecessor
    end else if (jhas_q && runner_q == jidom_q && runner_q != join_q) begin
      step_stop = 1'b1;                         // reached join's idom
    end else if ((cur_row & join_bit) != '0) begin
      step_stop = 1'b1;                         // already in frontier
    end else if (!(nd_valid && node_rdata.has_dom)) begin
      step_stop = 1'b1;                         // runner has no idom
    end else if (node_rdata.dom == runner_q || !in_range(node_rdata.dom, eff_count)) begin
      step_stop = 1'b1;                         // root or stale parent
    end else begin
      step_stop = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (item_err) begin
            state_d = ST_FIN;
          end else begin
            unique case (op)
              OP_EDGE: state_d = ST_JOIN;
              OP_READ: state_d = ST_RDATA;
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_JOIN:  state_d = ST_STEP;
      ST_STEP:  state_d = step_stop ? ST_FIN : ST_STEP;
      ST_RDATA: state_d = ST_FIN;
      ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    written_d  = written_q;
    rowv_d     = rowv_q;
    join_d     = join_q;
    runner_d   = runner_q;
    jhas_d     = jhas_q;
    jidom_d    = jidom_q;
    first_d    = first_q;
    res_row_d  = res_row_q;
    res_stat_d = res_stat_q;
    node_we    = 1'b0;
    node_waddr = block_i[AddrW-1:0];
    node_wdata = '{reach: reachable_i, has_dom: has_dominator_i, dom: dominator_i};
    node_raddr = runner_q[AddrW-1:0];
    fr_we      = 1'b0;
    fr_waddr   = runner_q[AddrW-1:0];
    fr_wdata   = cur_row | join_bit;
    fr_raddr   = runner_q[AddrW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          join_d     = block_i;
          runner_d   = predecessor_i;
          res_row_d  = '0;
          res_stat_d = item_err;
          node_raddr = block_i[AddrW-1:0];      // join's idom for an edge
          fr_raddr   = block_i[AddrW-1:0];      // row for a read
          if (!item_err) begin
            unique case (op)
              OP_CLEAR: rowv_d = '0;
              OP_LOAD: begin
                node_we = 1'b1;
                written_d[block_i[AddrW-1:0]] = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ST_JOIN: begin
        jhas_d  = written_q[join_q[AddrW-1:0]] && node_rdata.has_dom;
        jidom_d = node_rdata.dom;
        first_d = 1'b1;
        // reads of the predecessor issued with runner_q addresses (defaults)
      end
      ST_STEP: begin
        first_d = 1'b0;
        if (!(first_q && !(nd_valid && node_rdata.reach)) &&
            !(jhas_q && runner_q == jidom_q && runner_q != join_q) &&
            ((cur_row & join_bit) == '0)) begin
          fr_we = 1'b1;
          rowv_d[runner_q[AddrW-1:0]] = 1'b1;
        end
        if (!step_stop) begin
          runner_d   = node_rdata.dom;
          node_raddr = node_rdata.dom[AddrW-1:0];
          fr_raddr   = node_rdata.dom[AddrW-1:0];
        end
      end
      ST_RDATA: begin
        res_row_d = rowv_q[join_q[AddrW-1:0]] ? fr_rdata : '0;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // Output register: loaded from the result holding regs in ST_FIN.
  always_comb begin
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_stat_d  = out_stat_q;
    if (out_free) begin
      out_valid_d = 1'b0;
      if (state_q == ST_FIN) begin
        out_valid_d = 1'b1;
        out_row_d   = res_row_q;
        out_stat_d  = res_stat_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CountReset;
      written_q   <= '0;
      rowv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      written_q   <= written_d;
      rowv_q      <= rowv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    join_q     <= join_d;
    runner_q   <= runner_d;
    jhas_q     <= jhas_d;
    jidom_q    <= jidom_d;
    first_q    <= first_d;
    res_row_q  <= res_row_d;
    res_stat_q <= res_stat_d;
    out_row_q  <= out_row_d;
    out_stat_q <= out_stat_d;
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  dfb_ram #(
    .Width (NodeW),
    .Depth (MaxBlocks)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  dfb_ram #(
    .Width (RowW),
    .Depth (MaxBlocks)
  ) u_frontier_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign frontier_row_o = out_row_q;
  assign status_o       = out_stat_q;

endmodule

[dv/tb.sv]
// Self-checking testbench for the dominance frontier builder: driver, monitor and frontier model.
`timescale 1ns / 1ps

module tb;
  import dfb_pkg::*;

  // Run length guard. The slowest legal item adds the full climb, a receiver stall run
  // and a sender gap. About 850 items are run, and the guard leaves several times what
  // they then need.
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 80;   // beyond the longest climb
  localparam int ReportMax   = 10;

  // One graph operation as it appears on the input ports.
  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] blk;
    logic [IdxW-1:0] dom;
    logic            has_dom;
    logic            reach;
    logic [IdxW-1:0] pred;
  } graph_op_t;

  // One result transfer: the frontier row and the status bit.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic            status;
  } row_result_t;

  // Clock, reset and DUT ports; every input has a known value from time zero.
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [CountW-1:0] cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i            = '0;
  logic [IdxW-1:0]   block_i         = '0;
  logic [IdxW-1:0]   dominator_i     = '0;
  logic              has_dominator_i = 1'b0;
  logic              reachable_i     = 1'b0;
  logic [IdxW-1:0]   predecessor_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [RowW-1:0]   frontier_row_o;
  logic              status_o;

  // Operations waiting to be driven, and results the model says must come back.
  graph_op_t   graph_ops_q[$];
  row_result_t expected_rows_q[$];

  // Frontier model state: our own copy of the node table and the frontier matrix.
  logic [IdxW-1:0]   idom_mem [MaxBlocks];
  logic              idom_set [MaxBlocks];
  logic              live_mem [MaxBlocks];
  logic [RowW-1:0]   df_mem   [MaxBlocks];
  logic [CountW-1:0] block_count_q = CountReset;

  // Bookkeeping.
  int        op_tally [4];
  int        rejected_cnt  = 0;
  int        result_cnt    = 0;
  int        mismatch_cnt  = 0;
  int        drain_pauses  = 0;
  int        cycle_cnt     = 0;
  int        phase_cnt     = 0;
  graph_op_t on_bus;
  int        burst_left    = 4;
  int        burst_idx     = 0;
  int        gap_left      = 0;
  bit        hold_drain    = 1'b0;
  logic [7:0] stall_pat    = '0;
  int        stall_age     = 0;

  dominance_frontier_builder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .block_i         (block_i),
    .dominator_i     (dominator_i),
    .has_dominator_i (has_dominator_i),
    .reachable_i     (reachable_i),
    .predecessor_i   (predecessor_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frontier_row_o  (frontier_row_o),
    .status_o        (status_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frontier model
  // ---------------------------------------------------------------------------

  // Count actually in force: the register saturates at the table depth.
  function automatic int usable_blocks();
    return (block_count_q > CountMax) ? int'(MaxBlocks) : int'(block_count_q);
  endfunction

  // Walk from the predecessor up the dominator chain, marking the join node in each
  // runner's row. Stops at the join's idom (unless that runner is the join), at a bit
  // already set, at a runner with no idom, a self-dominating root, or a stale parent.
  function automatic void walk_frontier(int tgt, int start, int cnt);
    int              runner;
    int              parent;
    logic [RowW-1:0] tgt_bit;
    runner  = start;
    tgt_bit = '0;
    tgt_bit[tgt] = 1'b1;
    for (int s = 0; s <= int'(MaxBlocks); s++) begin
      if (idom_set[tgt] && runner == int'(idom_mem[tgt]) && runner != tgt) return;
      if ((df_mem[runner] & tgt_bit) != '0) return;
      df_mem[runner] |= tgt_bit;
      if (!idom_set[runner]) return;
      parent = int'(idom_mem[runner]);
      if (parent == runner || parent >= cnt) return;
      runner = parent;
    end
  endfunction

  // Apply one accepted operation to the model and return the result it must produce.
  function automatic row_result_t apply_graph_op(graph_op_t g);
    row_result_t r;
    int          cnt;
    r.row    = '0;
    r.status = 1'b0;
    cnt      = usable_blocks();
    case (g.op)
      OP_CLEAR: begin
        // clear touches only the matrix and never checks an index
        foreach (df_mem[i]) df_mem[i] = '0;
      end
      OP_LOAD: begin
        // the dominator index only matters when the node claims one
        if (int'(g.blk) >= cnt || (g.has_dom && int'(g.dom) >= cnt)) begin
          r.status = 1'b1;
        end else begin
          idom_mem[g.blk] = g.dom;
          idom_set[g.blk] = g.has_dom;
          live_mem[g.blk] = g.reach;
        end
      end
      OP_EDGE: begin
        if (int'(g.blk) >= cnt || int'(g.pred) >= cnt) begin
          r.status = 1'b1;
        end else if (live_mem[g.pred]) begin
          walk_frontier(int'(g.blk), int'(g.pred), cnt);
        end
        // an unreachable predecessor is accepted and changes nothing
      end
      default: begin
        if (int'(g.blk) >= cnt) r.status = 1'b1;
        else                    r.row    = df_mem[g.blk];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_op(op_e op, int blk, int dom, bit has_dom, bit reach,
                                   int pred);
    graph_op_t g;
    g.op      = op;
    g.blk     = IdxW'(blk);
    g.dom     = IdxW'(dom);
    g.has_dom = has_dom;
    g.reach   = reach;
    g.pred    = IdxW'(pred);
    graph_ops_q.push_back(g);
  endfunction

  // Fully random fields; out-of-range indices land here.
  function automatic void queue_noise();
    queue_op(op_e'(2'($urandom_range(3, 0))), $urandom_range(63, 0), $urandom_range(63, 0),
             1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom_range(63, 0));
  endfunction

  // A random dominator tree over the blocks in use, then mostly edges and reads on it,
  // with some reloads (which may form chains that loop or go stale), clears and noise.
  task automatic emit_random_graph(int budget);
    int cnt;
    int left;
    int k;
    int j;
    int tmp;
    int pick;
    int order [MaxBlocks];
    cnt  = usable_blocks();
    left = budget;
    if (cnt == 0) begin
      // every indexed op bounces; clears still go through
      for (k = 0; k < budget; k++) queue_noise();
      return;
    end
    if ($urandom_range(1, 0) == 1) begin
      queue_op(OP_CLEAR, $urandom_range(63, 0), $urandom_range(63, 0),
               1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom_range(63, 0));
      left--;
    end
    for (k = 0; k < cnt; k++) order[k] = k;
    for (k = cnt - 1; k > 0; k--) begin
      j        = $urandom_range(k, 0);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    // root: usually self-dominating, sometimes without an idom at all
    if ($urandom_range(3, 0) != 0)
      queue_op(OP_LOAD, order[0], order[0], 1'b1, 1'b1, $urandom_range(63, 0));
    else
      queue_op(OP_LOAD, order[0], $urandom_range(63, 0), 1'b0, 1'b1, $urandom_range(63, 0));
    for (k = 1; k < cnt; k++) begin
      queue_op(OP_LOAD, order[k], order[$urandom_range(k - 1, 0)],
               $urandom_range(9, 0) != 0, $urandom_range(7, 0) != 0, $urandom_range(63, 0));
    end
    left -= cnt;
    while (left > 0) begin
      pick = $urandom_range(31, 0);
      if (pick < 18) begin
        queue_op(OP_EDGE, order[$urandom_range(cnt - 1, 0)], $urandom_range(63, 0),
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                 order[$urandom_range(cnt - 1, 0)]);
      end else if (pick < 26) begin
        queue_op(OP_READ, order[$urandom_range(cnt - 1, 0)], $urandom_range(63, 0),
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom_range(63, 0));
      end else if (pick < 29) begin
        queue_noise();
      end else if (pick < 31) begin
        queue_op(OP_LOAD, order[$urandom_range(cnt - 1, 0)], $urandom_range(cnt - 1, 0),
                 $urandom_range(3, 0) != 0, $urandom_range(3, 0) != 0, $urandom_range(63, 0));
      end else begin
        queue_op(OP_CLEAR, $urandom_range(63, 0), $urandom_range(63, 0),
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom_range(63, 0));
      end
      left--;
    end
  endtask

  // Block count is only changed with the unit idle.
  task automatic write_block_count(int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    block_count_q  = CountW'(value);
    @(negedge clk_i);
  endtask

  // Every op returns exactly one result, so idle means nothing queued, nothing on
  // the bus and nothing outstanding.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (graph_ops_q.size() != 0 || in_valid_i || expected_rows_q.size() != 0);
    phase_cnt++;
  endtask

  function automatic void flag_mismatch(string field, logic [RowW-1:0] want,
                                        logic [RowW-1:0] got);
    if (mismatch_cnt < ReportMax)
      $display("[%0t] result %0d: %s mismatch, expected %h, got %h",
               $realtime, result_cnt, field, want, got);
    mismatch_cnt++;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops the op queue, runs bursts with random gaps, and holds valid and the
  // payload steady while stalled. The model is updated at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rows_q.push_back(apply_graph_op(on_bus));
        op_tally[on_bus.op]++;
        if (expected_rows_q[$].status) rejected_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (hold_drain && expected_rows_q.size() != 0) begin
          // pressure: sender waits for every result before going on
          in_valid_i <= 1'b0;
        end else if (graph_ops_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          hold_drain      = 1'b0;
          on_bus          = graph_ops_q.pop_front();
          op_i            <= on_bus.op;
          block_i         <= on_bus.blk;
          dominator_i     <= on_bus.dom;
          has_dominator_i <= on_bus.has_dom;
          reachable_i     <= on_bus.reach;
          predecessor_i   <= on_bus.pred;
          in_valid_i      <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_idx++;
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            // every eighth burst, and now and then otherwise, drain the pipe
            if (burst_idx % 8 == 0 || $urandom_range(15, 0) == 0) begin
              hold_drain = 1'b1;
              drain_pauses++;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest expectation and drives
  // the receiver stall from a rotating 8-bit pattern, redrawn when stall_age wraps.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    row_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rows_q.size() == 0) begin
          flag_mismatch("unexpected result, row", '0, frontier_row_o);
        end else begin
          want = expected_rows_q.pop_front();
          if (frontier_row_o !== want.row) flag_mismatch("frontier_row", want.row, frontier_row_o);
          if (status_o !== want.status)
            flag_mismatch("status", RowW'(want.status), RowW'(status_o));
        end
        result_cnt++;
      end
      stall_age++;
      if (stall_age == 48) begin
        stall_age = 0;
        case ($urandom_range(3, 0))
          0:       stall_pat = 8'h00;                  // free-running stretch
          1:       stall_pat = 8'($urandom);
          2:       stall_pat = 8'($urandom & $urandom);
          default: stall_pat = 8'($urandom | $urandom);
        endcase
      end
      out_stall_i <= stall_pat[0];
      stall_pat    = {stall_pat[0], stall_pat[7:1]};
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_rows_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed cases, then random graphs under a range of counts.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_counts[$];
    int k;
    foreach (idom_mem[i]) begin
      idom_mem[i] = '0;
      idom_set[i] = 1'b0;
      live_mem[i] = 1'b0;
      df_mem[i]   = '0;
    end
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, count 64 from reset: diamond 0 -> {1,2} -> 3 with idom(3) = 0.
    queue_op(OP_LOAD, 0, 0, 1'b1, 1'b1, 0);      // self-dominating root
    queue_op(OP_LOAD, 1, 0, 1'b1, 1'b1, 63);
    queue_op(OP_LOAD, 2, 0, 1'b1, 1'b1, 0);
    queue_op(OP_LOAD, 3, 0, 1'b1, 1'b1, 0);
    queue_op(OP_LOAD, 63, 63, 1'b0, 1'b0, 63);   // top index, unreachable, no idom
    queue_op(OP_LOAD, 5, 0, 1'b0, 1'b1, 0);      // join without a dominator
    queue_op(OP_EDGE, 3, 0, 1'b0, 1'b0, 1);
    queue_op(OP_EDGE, 3, 63, 1'b1, 1'b1, 2);
    queue_op(OP_EDGE, 3, 0, 1'b0, 1'b0, 1);      // bit already set
    queue_op(OP_EDGE, 3, 0, 1'b0, 1'b0, 63);     // unreachable predecessor
    queue_op(OP_EDGE, 5, 0, 1'b0, 1'b0, 2);      // climbs to the root, never meets idom
    queue_op(OP_READ, 2, 0, 1'b0, 1'b0, 0);
    queue_op(OP_READ, 0, 63, 1'b1, 1'b1, 63);
    queue_op(OP_CLEAR, 63, 63, 1'b1, 1'b1, 63);
    queue_op(OP_READ, 2, 0, 1'b0, 1'b0, 0);
    queue_op(OP_LOAD, 2, 50, 1'b1, 1'b1, 0);     // parent that goes stale below
    wait_idle();

    // Count 4: index checks and the stale parent.
    write_block_count(4);
    queue_op(OP_LOAD, 5, 0, 1'b1, 1'b1, 0);      // block out of range
    queue_op(OP_LOAD, 1, 9, 1'b1, 1'b1, 0);      // dominator out of range
    queue_op(OP_EDGE, 1, 0, 1'b0, 1'b0, 2);      // climb halts at parent 50
    queue_op(OP_EDGE, 9, 0, 1'b0, 1'b0, 0);
    queue_op(OP_EDGE, 0, 0, 1'b0, 1'b0, 9);
    queue_op(OP_READ, 9, 0, 1'b0, 1'b0, 0);
    queue_op(OP_READ, 2, 0, 1'b0, 1'b0, 0);
    wait_idle();

    // Count 0: everything but clear is rejected.
    write_block_count(0);
    queue_op(OP_CLEAR, 0, 0, 1'b0, 1'b0, 0);
    queue_op(OP_READ, 0, 0, 1'b0, 1'b0, 0);
    wait_idle();

    // Random graphs; the extremes plus a few random counts.
    phase_counts = {64, 1, 2, 127, 0, 5, 33, 100, 64};
    phase_counts.push_back($urandom_range(63, 3));
    phase_counts.push_back($urandom_range(64, 1));
    foreach (phase_counts[p]) begin
      write_block_count(phase_counts[p]);
      emit_random_graph((phase_counts[p] == 0) ? 15 : 80);
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    k = expected_rows_q.size();
    if (k != 0) $display("%0d expected results never arrived", k);

    $display("%0d transfers, %0d phases: %0d clear, %0d load, %0d edge, %0d read, %0d rejected",
             result_cnt, phase_cnt, op_tally[OP_CLEAR], op_tally[OP_LOAD], op_tally[OP_EDGE],
             op_tally[OP_READ], rejected_cnt);
    $display("Counts 0, 1, 2, 4, 5, 33, 64, 100, 127 and random; %0d drain pauses; %0d mismatches",
             drain_pauses, mismatch_cnt);
    if (mismatch_cnt == 0 && k == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
